@@ sv/assert_macros.svh @@
// Assertion macros shared by the tree-walk decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define HTWD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define HTWD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ sv/htwd_pkg.sv @@
// Types and constants of the tree-walk decoder.
`timescale 1ns / 1ps
`default_nettype none
package htwd_pkg;

	// Field widths of the request and result items
	localparam int unsigned IDX_W   = 9;
	localparam int unsigned SYM_W   = 8;
	localparam int unsigned CNT_W   = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned IDX_SPAN = 1 << IDX_W;

	// Request type codes on the input channel
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_BYTE  = 2'd2;

	// Command queue geometry
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QFILL_W     = 2;

	// Walk step counter: one setup step, then one step per code bit
	localparam int unsigned STEP_W    = 4;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BYTE_W);

	// One node of the code tree, packed as stored
	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             leaf;
		logic [IDX_W-1:0] right;
		logic [IDX_W-1:0] left;
	} htwd_node_t;

	// Command kinds after classification
	typedef enum logic [1:0] {
		OP_WRITE,
		OP_START,
		OP_BYTE
	} htwd_op_t;

	// Command carried from the front end to the walker
	typedef struct packed {
		htwd_op_t          op;
		logic [IDX_W-1:0]  idx;
		htwd_node_t        entry;
		logic [CNT_W-1:0]  count;
		logic [BYTE_W-1:0] code;
	} htwd_cmd_t;

	// Walker states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_FLUSH
	} htwd_state_t;

endpackage
`default_nettype wire

@@ sv/htwd_if.sv @@
// Valid/ready channel interfaces for requests and decoded symbols.
`timescale 1ns / 1ps
`default_nettype none
interface htwd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [8:0] node_index;
	logic [8:0] left_child;
	logic [8:0] right_child;
	logic       leaf_flag;
	logic [7:0] node_symbol;
	logic [31:0] symbol_count;
	logic [7:0] code_byte;

	modport source (
		output valid, req_type, node_index, left_child, right_child, leaf_flag,
		output node_symbol, symbol_count, code_byte,
		input  ready
	);
	modport sink (
		input  valid, req_type, node_index, left_child, right_child, leaf_flag,
		input  node_symbol, symbol_count, code_byte,
		output ready
	);
endinterface

interface htwd_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last_of_run;
	logic       stream_done;

	modport source (
		output valid, symbol, last_of_run, stream_done,
		input  ready
	);
	modport sink (
		input  valid, symbol, last_of_run, stream_done,
		output ready
	);
endinterface
`default_nettype wire

@@ sv/htwd_front.sv @@
// Front end: accepts request items and turns them into walker commands.
`timescale 1ns / 1ps
`default_nettype none
module htwd_front import htwd_pkg::*; #(
	parameter int unsigned NODE_DEPTH = 512
) (
	htwd_req_if.sink        req,
	input  logic            q_ready,
	output logic            cmd_valid,
	output htwd_cmd_t       cmd
);

	localparam logic [IDX_W:0] DEPTH_L = (IDX_W + 1)'(NODE_DEPTH);

	logic keep;

	// Classify: drop unknown requests and writes past the table
	always_comb begin
		keep          = 1'b0;
		cmd.op        = OP_BYTE;
		cmd.idx       = req.node_index;
		cmd.entry     = '{symbol: req.node_symbol, leaf: req.leaf_flag,
			right: req.right_child, left: req.left_child};
		cmd.count     = req.symbol_count;
		cmd.code      = req.code_byte;
		case (req.req_type)
			REQ_WRITE: begin
				cmd.op = OP_WRITE;
				keep   = ({1'b0, req.node_index} < DEPTH_L);
			end
			REQ_START: begin
				cmd.op = OP_START;
				keep   = 1'b1;
			end
			REQ_BYTE: begin
				cmd.op = OP_BYTE;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Take an item whenever the queue has room
	assign req.ready = q_ready;
	assign cmd_valid = req.valid && q_ready && keep;

endmodule
`default_nettype wire

@@ sv/htwd_queue.sv @@
// Short command queue between the front end and the walker.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module htwd_queue import htwd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  htwd_cmd_t push_cmd,
	output logic      can_take,
	input  logic      pop,
	output logic      has_cmd,
	output htwd_cmd_t head_cmd
);

	htwd_cmd_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QFILL_W-1:0]   fill_q;

	assign can_take = (fill_q != QFILL_W'(QUEUE_DEPTH));
	assign has_cmd  = (fill_q != '0);
	assign head_cmd = slot_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + QFILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - QFILL_W'(1);
			end
		end
	end

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	`HTWD_ASSERT(a_q_no_overflow, !(push && !can_take), "push into a full command queue")
	`HTWD_ASSERT(a_q_no_underflow, !(pop && !has_cmd), "pop from an empty command queue")
	`HTWD_ASSERT_IMP(a_q_ptr_gap, fill_q == '0, wr_ptr_q == rd_ptr_q,
		"empty queue with pointers apart")

endmodule
`default_nettype wire

@@ sv/htwd_walk.sv @@
// Back end: node table, bit-serial tree walk and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module htwd_walk import htwd_pkg::*; #(
	parameter int unsigned NODE_DEPTH = 512
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      has_cmd,
	input  htwd_cmd_t head_cmd,
	output logic      pop,
	htwd_res_if.source res
);

	localparam int unsigned    AW      = $clog2(NODE_DEPTH);
	localparam logic [IDX_W:0] DEPTH_L = (IDX_W + 1)'(NODE_DEPTH);

	htwd_node_t        mem [NODE_DEPTH];

	htwd_state_t       state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [BYTE_W-1:0] sh_q, sh_d;
	logic [IDX_W-1:0]  pos_q, pos_d;
	logic [CNT_W-1:0]  left_q, left_d;
	logic              pend_valid_q, pend_valid_d;
	logic [SYM_W-1:0]  pend_sym_q, pend_sym_d;
	logic              pend_done_q, pend_done_d;
	logic [IDX_W-1:0]  raddr_q;
	logic              rd_oob_q;
	htwd_node_t        rdata_q;
	htwd_node_t        root_q;
	logic              out_valid_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_last_q;
	logic              out_done_q;

	logic              mem_we;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              rd_in_range;
	htwd_node_t        child;
	htwd_node_t        cur;
	logic              can_push;
	logic              push;
	logic              push_last;

	assign child       = rd_oob_q ? htwd_node_t'('0) : rdata_q;
	assign can_push    = !out_valid_q || res.ready;
	assign rd_in_range = ({1'b0, rd_addr} < DEPTH_L);

	// Next state: dequeue commands, walk one bit per step, flush the held symbol
	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		sh_d         = sh_q;
		pos_d        = pos_q;
		left_d       = left_q;
		pend_valid_d = pend_valid_q;
		pend_sym_d   = pend_sym_q;
		pend_done_d  = pend_done_q;
		pop          = 1'b0;
		mem_we       = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = raddr_q;
		cur          = child;
		push         = 1'b0;
		push_last    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (has_cmd) begin
					pop = 1'b1;
					case (head_cmd.op)
						OP_WRITE: begin
							mem_we = 1'b1;
						end
						OP_START: begin
							left_d = head_cmd.count;
							pos_d  = '0;
						end
						OP_BYTE: begin
							if (left_q != '0) begin
								rd_en   = 1'b1;
								rd_addr = pos_q;
								sh_d    = head_cmd.code;
								step_d  = '0;
								state_d = BK_WALK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			BK_WALK: begin
				if (step_q == '0) begin
					// read data is the node at the walk position: fetch its child
					rd_en   = 1'b1;
					rd_addr = sh_q[BYTE_W-1] ? child.right : child.left;
					sh_d    = sh_q << 1;
					step_d  = step_q + STEP_W'(1);
				end else if (!(child.leaf && pend_valid_q && !can_push)) begin
					if (child.leaf) begin
						// leaf: release the held symbol, hold this one, back to root
						push         = pend_valid_q;
						pend_valid_d = 1'b1;
						pend_sym_d   = child.symbol;
						pend_done_d  = (left_q == CNT_W'(1));
						left_d       = left_q - CNT_W'(1);
						pos_d        = '0;
						cur          = root_q;
					end else begin
						pos_d = raddr_q;
						cur   = child;
					end
					if (step_q == STEP_LAST || (child.leaf && left_q == CNT_W'(1))) begin
						state_d = BK_FLUSH;
					end else begin
						rd_en   = 1'b1;
						rd_addr = sh_q[BYTE_W-1] ? cur.right : cur.left;
						sh_d    = sh_q << 1;
						step_d  = step_q + STEP_W'(1);
					end
				end
			end
			BK_FLUSH: begin
				if (!pend_valid_q) begin
					state_d = BK_IDLE;
				end else if (can_push) begin
					push         = 1'b1;
					push_last    = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			step_q       <= '0;
			pos_q        <= '0;
			left_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_done_q  <= 1'b0;
			raddr_q      <= '0;
			rd_oob_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			step_q       <= step_d;
			pos_q        <= pos_d;
			left_q       <= left_d;
			pend_valid_q <= pend_valid_d;
			pend_done_q  <= pend_done_d;
			if (rd_en) begin
				raddr_q  <= rd_addr;
				rd_oob_q <= !rd_in_range;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold payload: shift register, held symbol, result register, root copy
	always_ff @(posedge clk) begin
		sh_q       <= sh_d;
		pend_sym_q <= pend_sym_d;
		if (push) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= push_last;
			out_done_q <= pend_done_q;
		end
		if (mem_we && head_cmd.idx == '0) begin
			root_q <= head_cmd.entry;
		end
	end

	// Write the node table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head_cmd.idx[AW-1:0]] <= head_cmd.entry;
		end
	end

	// Read the node table, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr[AW-1:0]];
		end
	end

	assign res.valid       = out_valid_q;
	assign res.symbol      = out_sym_q;
	assign res.last_of_run = out_last_q;
	assign res.stream_done = out_done_q;

	`HTWD_ASSERT_IMP(a_walk_has_count, state_q == BK_WALK, left_q != '0,
		"walking a byte with no symbols left")
	`HTWD_ASSERT_IMP(a_idle_no_pending, state_q == BK_IDLE, !pend_valid_q,
		"symbol still held while idle")
	`HTWD_ASSERT(a_step_range, step_q <= STEP_LAST, "walk step beyond last code bit")

endmodule
`default_nettype wire

@@ sv/huffman_tree_walk_decoder_top.sv @@
// Huffman decoder that walks a stored code tree: top level.
// Channel req (sink) carries request items: req_type 0 writes node_index of
// the node table, 1 starts a stream of symbol_count symbols at the root, 2
// delivers one compressed code_byte, taken most significant bit first.
// Channel res (source) returns one item per decoded symbol, with last_of_run
// on the last symbol taken from a byte and stream_done on the final symbol.
// Requests pass a two-entry command queue, so req keeps accepting while the
// walker works or res is stalled. A write or start is done as it is dequeued;
// a byte passes through a dequeue and position read, one table read per code
// bit for 8 bits, a test of the child of the last bit, then a flush, ending
// sooner when the count runs out mid-byte. Each node-table read per code bit
// depends on the read before it.
// A symbol is held until the next one is found or the byte ends, and is then
// passed to the result register that drives res.
// When res stalls, the walker stops at the next symbol and the queue fills,
// then req drops ready. Reset clears the walk position and symbol count; the
// node table is not cleared and must be written before it is walked.
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_walk_decoder_top import htwd_pkg::*; #(
	parameter int unsigned MAX_NODES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	htwd_req_if.sink    req,
	htwd_res_if.source  res
);

	localparam int unsigned NODE_DEPTH = (MAX_NODES > IDX_SPAN) ? IDX_SPAN : MAX_NODES;

	logic      q_ready;
	logic      cmd_valid;
	htwd_cmd_t cmd;
	logic      has_cmd;
	htwd_cmd_t head_cmd;
	logic      pop;

	htwd_front #(
		.NODE_DEPTH (NODE_DEPTH)
	) u_front (
		.req       (req),
		.q_ready   (q_ready),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	htwd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_valid),
		.push_cmd (cmd),
		.can_take (q_ready),
		.pop      (pop),
		.has_cmd  (has_cmd),
		.head_cmd (head_cmd)
	);

	htwd_walk #(
		.NODE_DEPTH (NODE_DEPTH)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.has_cmd  (has_cmd),
		.head_cmd (head_cmd),
		.pop      (pop),
		.res      (res)
	);

endmodule
`default_nettype wire
